// File: rtl/core/tks_pkg.sv
// Shared types and widths for the top-k smallest selector.
`default_nettype none
package tks_pkg;

    localparam int DIST_W  = 32;
    localparam int INDEX_W = 16;
    localparam int CFG_W   = 5;
    localparam int KEFF_W  = 8;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] index;
    } entry_t;

    typedef struct packed {
        logic insert;  // new distance enters the chain this cycle
        logic drain;   // chain shifts toward the head by one place
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/tks_cell.sv
// One slot of the sorted list: compare, hold, shift.
`default_nettype none
module tks_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tks_pkg::cell_ctrl_t ctrl,
    input  wire logic               enable,
    input  wire tks_pkg::entry_t    new_entry,
    input  wire logic               prev_ins,
    input  wire tks_pkg::entry_t    prev_entry,
    input  wire logic               prev_valid,
    input  wire tks_pkg::entry_t    next_entry,
    input  wire logic               next_valid,
    output tks_pkg::entry_t         entry,
    output logic                    valid,
    output logic                    ins
);

    tks_pkg::entry_t entry_reg;
    tks_pkg::entry_t entry_next;
    logic            valid_reg;
    logic            valid_next;

    // Slots past the active limit are treated as empty.
    assign valid = valid_reg && enable;
    assign entry = entry_reg;
    // Insertion point is at or before this slot.
    assign ins   = !valid || (new_entry.distance < entry_reg.distance);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid;
        priority if (ctrl.drain)
        begin
            entry_next = next_entry;
            valid_next = next_valid;
        end
        else if (ctrl.insert)
        begin
            priority if (prev_ins)
            begin
                entry_next = prev_entry;
                valid_next = prev_valid;
            end
            else if (ins)
            begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end
            else
            begin
                valid_next = valid;
            end
            valid_next = valid_next && enable;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

// File: rtl/core/top_k_smallest_selector_top.sv
// Top level of the top-k smallest selector: cell chain, column counter, drain control.
`default_nettype none
// Accepts one distance per cycle while a row streams in; each distance is
// compared against every slot of a chain of MAX_K cells at once and inserted
// into the cell registers when accepted. The request flagged row_end starts
// a drain: the kept list (min(active_k, columns seen) entries) leaves one
// result per cycle while nbr_ready is high, from the head cell while the chain
// shifts toward it, and no distance is taken until the last result is
// delivered. active_k of 0 acts as 1 and values above MAX_K act as MAX_K.
// Column indices saturate at the top index; further columns set row_too_long
// on every result of that row.
module top_k_smallest_selector_top #(
    parameter int MAX_K       = 16,
    parameter int MAX_ROW_LEN = 65536
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tks_pkg::CFG_W-1:0]    active_k,
    input  wire logic                         dist_valid,
    output logic                              dist_ready,
    input  wire logic [tks_pkg::DIST_W-1:0]   distance,
    input  wire logic                         row_end,
    output logic                              nbr_valid,
    input  wire logic                         nbr_ready,
    output logic [tks_pkg::INDEX_W-1:0]       neighbor_index,
    output logic [tks_pkg::DIST_W-1:0]        neighbor_distance,
    output logic                              list_last,
    output logic                              row_too_long
);

    localparam logic [tks_pkg::INDEX_W-1:0] COL_TOP =
        (MAX_ROW_LEN > 65536) ? {tks_pkg::INDEX_W{1'b1}}
                              : tks_pkg::INDEX_W'(MAX_ROW_LEN - 1);
    localparam logic [tks_pkg::KEFF_W-1:0] K_MAX = tks_pkg::KEFF_W'(MAX_K);

    typedef enum logic {ST_FILL, ST_DRAIN} state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [tks_pkg::CFG_W-1:0]     k_cfg_reg;
    logic [tks_pkg::INDEX_W-1:0]   col_reg;
    logic [tks_pkg::INDEX_W-1:0]   col_next;
    logic                          top_used_reg;
    logic                          top_used_next;
    logic                          ovf_reg;
    logic                          ovf_next;

    logic [tks_pkg::KEFF_W-1:0]    k_raw;
    logic [tks_pkg::KEFF_W-1:0]    k_eff;
    logic                          dist_acc;
    logic                          nbr_acc;
    logic                          at_top;
    logic                          ovf_step;
    tks_pkg::cell_ctrl_t           ctrl;
    tks_pkg::entry_t               new_entry;

    tks_pkg::entry_t               cell_entry [MAX_K];
    logic [MAX_K-1:0]              cell_valid;
    logic [MAX_K-1:0]              cell_ins;
    logic [MAX_K-1:0]              cell_en;

    assign cfg_ready  = 1'b1;
    assign dist_ready = (state_reg == ST_FILL);
    assign nbr_valid  = (state_reg == ST_DRAIN);
    assign dist_acc   = dist_valid && dist_ready;
    assign nbr_acc    = nbr_valid && nbr_ready;

    assign k_raw = tks_pkg::KEFF_W'(k_cfg_reg);
    always_comb
    begin
        priority if (k_raw == '0)
        begin
            k_eff = tks_pkg::KEFF_W'(1);
        end
        else if (k_raw > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = k_raw;
        end
    end

    assign at_top   = (col_reg == COL_TOP);
    assign ovf_step = ovf_reg || (at_top && top_used_reg);

    assign new_entry.distance = distance;
    assign new_entry.index    = col_reg;
    assign ctrl.insert        = dist_acc;
    assign ctrl.drain         = nbr_acc;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_K; gi++)
        begin : g_cell
            logic            p_ins;
            logic            p_valid;
            tks_pkg::entry_t p_entry;
            logic            n_valid;
            tks_pkg::entry_t n_entry;

            assign cell_en[gi] = (tks_pkg::KEFF_W'(gi) < k_eff);

            if (gi == 0)
            begin : g_head
                assign p_ins   = 1'b0;
                assign p_valid = 1'b0;
                assign p_entry = new_entry;
            end
            else
            begin : g_body
                assign p_ins   = cell_ins[gi-1];
                assign p_valid = cell_valid[gi-1];
                assign p_entry = cell_entry[gi-1];
            end

            if (gi == MAX_K - 1)
            begin : g_tail
                assign n_valid = 1'b0;
                assign n_entry = cell_entry[gi];
            end
            else
            begin : g_mid
                assign n_valid = cell_valid[gi+1];
                assign n_entry = cell_entry[gi+1];
            end

            tks_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .enable     (cell_en[gi]),
                .new_entry  (new_entry),
                .prev_ins   (p_ins),
                .prev_entry (p_entry),
                .prev_valid (p_valid),
                .next_entry (n_entry),
                .next_valid (n_valid),
                .entry      (cell_entry[gi]),
                .valid      (cell_valid[gi]),
                .ins        (cell_ins[gi])
            );
        end
    endgenerate

    assign neighbor_index    = cell_entry[0].index;
    assign neighbor_distance = cell_entry[0].distance;
    assign row_too_long      = ovf_reg;
    generate
        if (MAX_K > 1)
        begin : g_last_multi
            assign list_last = !cell_valid[1];
        end
        else
        begin : g_last_single
            assign list_last = 1'b1;
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        top_used_next = top_used_reg;
        ovf_next      = ovf_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (dist_acc)
                begin
                    if (row_end)
                    begin
                        state_next    = ST_DRAIN;
                        col_next      = '0;
                        top_used_next = 1'b0;
                        ovf_next      = ovf_step;
                    end
                    else
                    begin
                        col_next      = at_top ? col_reg : col_reg + 1'b1;
                        top_used_next = top_used_reg || at_top;
                        ovf_next      = ovf_step;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (nbr_acc && list_last)
                begin
                    state_next = ST_FILL;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            k_cfg_reg    <= tks_pkg::CFG_W'(16);
            col_reg      <= '0;
            top_used_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            top_used_reg <= top_used_next;
            ovf_reg      <= ovf_next;
            if (cfg_valid && cfg_ready)
            begin
                k_cfg_reg <= active_k;
            end
        end
    end

    // Kept slots always form a run starting at the head.
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid & (cell_valid + 1'b1)) == '0))
        else $error("kept slots not contiguous");

    a_head_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("drain with empty head slot");

    a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (dist_acc && row_end) |=> (state_reg == ST_DRAIN) && (col_reg == '0)
                                  && !top_used_reg)
        else $error("row end did not start drain");

    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        $past(dist_acc) |-> ((cell_valid & ~cell_en) == '0))
        else $error("slot kept past active limit");

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Testbench for top_k_smallest_selector_top: directed table, random rows, predictor check.
module testbench;

    localparam int MAX_K       = 16;
    localparam int MAX_ROW_LEN = 65536;
    localparam int COL_TOP     = (MAX_ROW_LEN > 65536) ? 65535 : MAX_ROW_LEN - 1;
    localparam int DRAIN_GAP   = 2 * MAX_K + 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 48;

    typedef struct packed {
        logic [tks_pkg::INDEX_W-1:0] index;
        logic [tks_pkg::DIST_W-1:0]  distance;
        logic                        last;
        logic                        too_long;
    } neighbor_t;

    typedef struct packed {
        bit                          write_cfg;
        logic [tks_pkg::CFG_W-1:0]   limit;
        logic [tks_pkg::DIST_W-1:0]  distance;
        logic                        last;
        int                          fill;
        logic [tks_pkg::DIST_W-1:0]  fill_base;
        bit                          typed;
        neighbor_t                   want;
    } step_t;

    localparam neighbor_t NONE = '0;
    localparam int N_PLAN = 20;

    // fill columns precede the row's own request, distance fill_base + (j % 5)
    step_t plan [N_PLAN] = '{
        '{1'b0, 5'd0,  32'h0000_0000, 1'b1, 0,     32'h0,      1'b1,
          '{16'd0, 32'h0000_0000, 1'b1, 1'b0}},
        '{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b1, 0,     32'h0,      1'b1,
          '{16'd0, 32'hFFFF_FFFF, 1'b1, 1'b0}},
        '{1'b0, 5'd0,  32'h0000_0005, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h0000_0005, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h0000_0003, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h0000_0005, 1'b1, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h0000_0000, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h8000_0000, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h7FFF_FFFF, 1'b1, 0,     32'h0,      1'b0, NONE},
        '{1'b1, 5'd1,  32'h0000_0009, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h0000_0004, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h0000_0004, 1'b1, 0,     32'h0,      1'b1,
          '{16'd1, 32'h0000_0004, 1'b1, 1'b0}},
        '{1'b1, 5'd0,  32'h0000_0002, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h0000_0001, 1'b1, 0,     32'h0,      1'b1,
          '{16'd1, 32'h0000_0001, 1'b1, 1'b0}},
        '{1'b1, 5'd31, 32'h0000_0000, 1'b1, 19,    32'd100,    1'b0, NONE},
        '{1'b1, 5'd17, 32'h0000_0041, 1'b1, 16,    32'h40,     1'b0, NONE},
        '{1'b0, 5'd0,  32'h0000_0007, 1'b1, 0,     32'h0,      1'b1,
          '{16'd0, 32'h0000_0007, 1'b1, 1'b0}},
        '{1'b1, 5'd2,  32'h0000_0003, 1'b0, 0,     32'h0,      1'b0, NONE},
        '{1'b0, 5'd0,  32'h0000_0003, 1'b1, 0,     32'h0,      1'b0, NONE}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tks_pkg::CFG_W-1:0]     active_k = '0;
    logic                          dist_valid = 1'b0;
    logic                          dist_ready;
    logic [tks_pkg::DIST_W-1:0]    distance = '0;
    logic                          row_end = 1'b0;
    logic                          nbr_valid;
    logic                          nbr_ready = 1'b0;
    logic [tks_pkg::INDEX_W-1:0]   neighbor_index;
    logic [tks_pkg::DIST_W-1:0]    neighbor_distance;
    logic                          list_last;
    logic                          row_too_long;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // selector state mirror
    logic [tks_pkg::CFG_W-1:0] limit_reg = 5'd16;
    tks_pkg::entry_t           kept [MAX_K];
    int                        kept_len = 0;
    int                        column = 0;
    bit                        overflow = 1'b0;
    bit                        top_taken = 1'b0;
    neighbor_t                 pending_neighbors [$];
    neighbor_t                 head;

    top_k_smallest_selector_top #(
        .MAX_K       (MAX_K),
        .MAX_ROW_LEN (MAX_ROW_LEN)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .active_k          (active_k),
        .dist_valid        (dist_valid),
        .dist_ready        (dist_ready),
        .distance          (distance),
        .row_end           (row_end),
        .nbr_valid         (nbr_valid),
        .nbr_ready         (nbr_ready),
        .neighbor_index    (neighbor_index),
        .neighbor_distance (neighbor_distance),
        .list_last         (list_last),
        .row_too_long      (row_too_long)
    );

    always #4 clk = ~clk;

    function automatic int effective_k();
        int k;
        k = limit_reg;
        if (k == 0) k = 1;
        if (k > MAX_K) k = MAX_K;
        return k;
    endfunction

    task automatic take_distance(input logic [tks_pkg::DIST_W-1:0] d, input logic last,
                                 input bit typed, input neighbor_t want);
        int k;
        int pos;
        int i;
        logic [tks_pkg::INDEX_W-1:0] col;
        neighbor_t nb;
        k = effective_k();
        if (kept_len > k) kept_len = k;
        if (column >= COL_TOP)
        begin
            column = COL_TOP;
            if (top_taken) overflow = 1'b1;
            top_taken = 1'b1;
        end
        col = column[tks_pkg::INDEX_W-1:0];
        if (column < COL_TOP) column++;
        pos = 0;
        while (pos < kept_len && !(d < kept[pos].distance)) pos++;
        if (pos < k)
        begin
            i = (kept_len < k) ? kept_len : k - 1;
            while (i > pos)
            begin
                kept[i] = kept[i-1];
                i--;
            end
            kept[pos].distance = d;
            kept[pos].index    = col;
            if (kept_len < k) kept_len++;
        end
        if (last)
        begin
            if (typed)
                pending_neighbors.push_back(want);
            else
                for (i = 0; i < kept_len; i++)
                begin
                    nb.index    = kept[i].index;
                    nb.distance = kept[i].distance;
                    nb.last     = (i == kept_len - 1);
                    nb.too_long = overflow;
                    pending_neighbors.push_back(nb);
                end
            kept_len  = 0;
            column    = 0;
            overflow  = 1'b0;
            top_taken = 1'b0;
        end
    endtask

    task automatic send_distance(input logic [tks_pkg::DIST_W-1:0] d, input logic last,
                                 input bit typed, input neighbor_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            dist_valid <= 1'b0;
            @(posedge clk);
        end
        dist_valid <= 1'b1;
        distance   <= d;
        row_end    <= last;
        do @(posedge clk); while (!dist_ready);
        take_distance(d, last, typed, want);
    endtask

    task automatic wait_idle();
        dist_valid <= 1'b0;
        while (pending_neighbors.size() != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_limit(input logic [tks_pkg::CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        active_k  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    function automatic logic [tks_pkg::CFG_W-1:0] pick_limit();
        case ($urandom_range(0, 6))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd2;
            3: return 5'd16;
            4: return 5'd17;
            5: return 5'd31;
            default: return tks_pkg::CFG_W'($urandom_range(0, 31));
        endcase
    endfunction

    task automatic compare_field(input string name,
                                 input logic [tks_pkg::DIST_W-1:0] want,
                                 input logic [tks_pkg::DIST_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        nbr_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && nbr_valid && nbr_ready)
        begin
            if (pending_neighbors.size() == 0)
            begin
                $display("%0t unexpected neighbor index %0h distance %0h", $time,
                         neighbor_index, neighbor_distance);
                mismatch_count++;
            end
            else
            begin
                head = pending_neighbors.pop_front();
                compare_field("neighbor_index", tks_pkg::DIST_W'(head.index),
                              tks_pkg::DIST_W'(neighbor_index));
                compare_field("neighbor_distance", head.distance, neighbor_distance);
                compare_field("list_last", tks_pkg::DIST_W'(head.last),
                              tks_pkg::DIST_W'(list_last));
                compare_field("row_too_long", tks_pkg::DIST_W'(head.too_long),
                              tks_pkg::DIST_W'(row_too_long));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((dist_valid && dist_ready) || (nbr_valid && nbr_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[top_k_smallest_selector_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int i;
        int j;
        int phase;
        int sent;
        int len;
        int mode;
        logic [tks_pkg::DIST_W-1:0] base;
        logic [tks_pkg::DIST_W-1:0] d;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_PLAN; i++)
        begin
            if (plan[i].write_cfg) write_limit(plan[i].limit);
            for (j = 0; j < plan[i].fill; j++)
                send_distance(plan[i].fill_base + (j % 5), 1'b0, 1'b0, NONE);
            send_distance(plan[i].distance, plan[i].last, plan[i].typed, plan[i].want);
        end

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            write_limit(pick_limit());
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 7) == 0)
                    wait_idle();
                else if ($urandom_range(0, 5) == 0)
                    write_limit(pick_limit());
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 40)
                                                    : $urandom_range(1, 20);
                mode = $urandom_range(0, 4);
                base = $urandom;
                for (j = 0; j < len; j++)
                begin
                    case (mode)
                        0: d = $urandom;
                        1: d = $urandom_range(0, 7);
                        2:
                            case ($urandom_range(0, 3))
                                0: d = 32'h0000_0000;
                                1: d = 32'hFFFF_FFFF;
                                2: d = 32'h8000_0000;
                                default: d = 32'h7FFF_FFFF;
                            endcase
                        3: d = base + j;
                        default: d = base - j;
                    endcase
                    send_distance(d, j == len - 1, 1'b0, NONE);
                end
                sent += len;
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("[top_k_smallest_selector_top] OK");
        else
            $display("[top_k_smallest_selector_top] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tks_pkg.sv
rtl/core/tks_cell.sv
rtl/core/top_k_smallest_selector_top.sv
dv/testbench.sv
